/* hw/rtl/deq_pkg.sv */
// deq_pkg: command codes, status codes, controller state and control struct
// for the double-ended queue. No dependencies; imported by every deque module.
package deq_pkg;

    // command codes on the cmd port (6 and 7 act as peek)
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_REAR  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_REAR   = 3'd3;
    localparam logic [2:0] CMD_CLEAR      = 3'd4;
    localparam logic [2:0] CMD_PEEK       = 3'd5;

    // status codes returned with every result
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_RESP = 3'b100
    } deq_state_t;

    // controller -> datapath commands
    typedef struct packed {
        logic exec;   // apply the request on the ports this cycle
        logic load;   // register front/rear words from slot memory
    } deq_ctl_t;

endpackage

/* hw/rtl/deq_ctrl.sv */
// deq_ctrl: request sequencer for the double-ended queue.
// Depends on deq_pkg (state type, control struct).
module deq_ctrl
    import deq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    output logic     done,
    output deq_ctl_t ctl
);

    deq_state_t state_reg;
    deq_state_t state_next;
    logic       accept;

    assign busy   = (state_reg == ST_READ);
    assign done   = (state_reg == ST_RESP);
    assign accept = start && !busy;

    assign ctl.exec = accept;
    assign ctl.load = (state_reg == ST_READ);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                state_next = accept ? ST_READ : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* hw/rtl/deq_datapath.sv */
// deq_datapath: slot memory, head pointer, count and result registers.
// Depends on deq_pkg (command/status codes, control struct).
module deq_datapath
    import deq_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  deq_ctl_t           ctl,
    input  logic [2:0]         cmd,
    input  logic signed [31:0] push_value,
    output logic signed [31:0] front_word,
    output logic signed [31:0] rear_word,
    output logic [4:0]         occupancy,
    output logic               is_empty,
    output logic [1:0]         status
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_S   = SUM_W'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);

    logic [WORD_BITS-1:0] mem [DEPTH];

    logic [IDX_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [1:0]           status_reg, status_next;
    logic [WORD_BITS-1:0] front_reg, rear_reg;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_idx;
    logic [WORD_BITS-1:0] wr_word;

    logic                 full, empty;
    logic [IDX_W-1:0]     prev_idx, succ_idx;
    logic [SUM_W-1:0]     tail_sum, tail_wrap;
    logic [SUM_W-1:0]     rear_sum, rear_wrap;
    logic [IDX_W-1:0]     tail_idx, rear_idx;

    assign full    = (count_reg == DEPTH_C);
    assign empty   = (count_reg == '0);
    assign wr_word = WORD_BITS'(push_value);

    assign prev_idx = (head_reg == '0) ? LAST_IDX : head_reg - IDX_W'(1);
    assign succ_idx = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);

    // slot just past the rear
    assign tail_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_wrap = (tail_sum >= DEPTH_S) ? tail_sum - DEPTH_S : tail_sum;
    assign tail_idx  = tail_wrap[IDX_W-1:0];

    // rear slot; meaningless when empty, masked at the output
    assign rear_sum  = tail_sum - SUM_W'(1);
    assign rear_wrap = (rear_sum >= DEPTH_S) ? rear_sum - DEPTH_S : rear_sum;
    assign rear_idx  = rear_wrap[IDX_W-1:0];

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        wr_idx      = tail_idx;
        if (ctl.exec)
        begin
            status_next = STATUS_OK;
            unique case (cmd)
                CMD_PUSH_FRONT:
                begin
                    if (full)
                        status_next = STATUS_FULL;
                    else
                    begin
                        head_next  = prev_idx;
                        wr_en      = 1'b1;
                        wr_idx     = prev_idx;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_PUSH_REAR:
                begin
                    if (full)
                        status_next = STATUS_FULL;
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_POP_FRONT:
                begin
                    if (empty)
                        status_next = STATUS_EMPTY;
                    else
                    begin
                        head_next  = succ_idx;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                CMD_POP_REAR:
                begin
                    if (empty)
                        status_next = STATUS_EMPTY;
                    else
                        count_next = count_reg - CNT_W'(1);
                end
                CMD_CLEAR:
                begin
                    head_next  = '0;
                    count_next = '0;
                end
                default:
                begin
                    // peek and unused codes: no change
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            count_reg  <= '0;
            status_reg <= STATUS_OK;
        end
        else
        begin
            head_reg   <= head_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx] <= wr_word;
        if (ctl.load)
        begin
            front_reg <= mem[head_reg];
            rear_reg  <= mem[rear_idx];
        end
    end

    assign is_empty   = empty;
    assign occupancy  = 5'(count_reg);
    assign status     = status_reg;
    assign front_word = empty ? '1 : 32'($signed(front_reg));
    assign rear_word  = empty ? '1 : 32'($signed(rear_reg));

endmodule

/* hw/rtl/double_ended_queue.sv */
// double_ended_queue: top level of the bounded deque (ring buffer in a
// slot memory). Depends on deq_pkg, deq_ctrl and deq_datapath.
//
//  channel   handshake            payload
//  -------   -------------------  ----------------------------------------
//  request   start / busy         cmd, push_value
//  result    done (1-cycle pulse) front_word, rear_word, occupancy,
//                                 is_empty, status
//
// Timing: a request is taken at an edge with start high and busy low; the
// head, count and slot write are applied at that same edge. The next cycle
// (busy high) reads front and rear slots from the memory's two read ports,
// and the cycle after that shows the result with done high.
// One request every 2 cycles sustained: a new request may be taken in the
// result cycle. The memory's registered read sets this figure.
// Reset clears head, count and status at once; slot contents are not cleared
// and need no clearing pass, since only written slots are ever shown.
// The result side has no stall; done is never held off.
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         cmd,
    input  logic signed [31:0] push_value,
    output logic               done,
    output logic signed [31:0] front_word,
    output logic signed [31:0] rear_word,
    output logic [4:0]         occupancy,
    output logic               is_empty,
    output logic [1:0]         status
);

    deq_ctl_t ctl;

    // sequencer: accept, read, respond
    deq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctl   (ctl)
    );

    // pointers, count, slot memory and result words
    deq_datapath #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .cmd        (cmd),
        .push_value (push_value),
        .front_word (front_word),
        .rear_word  (rear_word),
        .occupancy  (occupancy),
        .is_empty   (is_empty),
        .status     (status)
    );

endmodule

/* hw/rtl/deq_checker.sv */
// deq_checker: port-level assertions for double_ended_queue, bound to it.
// Depends on deq_pkg (status codes) and the double_ended_queue ports.
module deq_checker
    import deq_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [31:0] front_word,
    input logic signed [31:0] rear_word,
    input logic [4:0]         occupancy,
    input logic               is_empty,
    input logic [1:0]         status
);

    // every accepted request yields its result after the read state
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("result missing two cycles after request");

    // busy lasts a single cycle
    a_busy_short: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    // an empty result shows both words as all ones (-1) and zero occupancy
    a_empty_words: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_empty) |->
            (front_word == -32'sd1 && rear_word == -32'sd1 && occupancy == 5'd0))
        else $error("empty result with data or occupancy");

    // a pop is only refused on an empty queue
    a_pop_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STATUS_EMPTY) |-> is_empty)
        else $error("pop refused on a queue that holds data");

    // no result without a request behind it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a request");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .front_word (front_word),
    .rear_word  (rear_word),
    .occupancy  (occupancy),
    .is_empty   (is_empty),
    .status     (status)
);
